FILE: rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg : shared definitions for the max-tracking stack
// Sizes, operation and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // a transaction is accepted this cycle
    logic finish;  // memory data is ready and the result register is free
  } smt_cmd_t;

endpackage

FILE: rtl/smt_ram.sv
// ----------------------------------------------------------------------------
// smt_ram : generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl : sequencing controller
// Accepts one transaction, waits for the memory read, then hands
// the result to the output register when that register is free.
// ----------------------------------------------------------------------------
module smt_ctrl
  import smt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output smt_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  assign cmd.start  = in_tvalid && in_tready;
  assign cmd.finish = (state_r == S_FINISH) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // A new result replaces one that is taken at the same edge.
      if (cmd.finish) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.finish) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/smt_datapath.sv
// ----------------------------------------------------------------------------
// smt_datapath : pair store, maxima store and result register
// The top pair and the top maximum live in registers; the entries below them
// live in two RAMs. A pop reads the entry that becomes the new top.
// ----------------------------------------------------------------------------
module smt_datapath
  import smt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  smt_cmd_t                cmd,
  input  logic                    in_func,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic signed [KEY_W-1:0] out_top_key,
  output logic signed [VAL_W-1:0] out_top_value,
  output logic signed [KEY_W-1:0] out_max_key,
  output logic                    out_is_empty,
  output status_t                 out_status
);

  localparam int PAIR_W = KEY_W + VAL_W;
  localparam int MAX_W  = KEY_W + CNT_W;

  logic [CNT_W-1:0]        fill_r, fill_nxt, mc_r, mc_nxt;
  logic [CNT_W-1:0]        fill_m1, fill_m2, mc_m1, mc_m2;
  logic signed [KEY_W-1:0] top_key_r, top_key_nxt, max_key_r, max_key_nxt;
  logic signed [VAL_W-1:0] top_val_r, top_val_nxt;
  logic [CNT_W-1:0]        max_rep_r, max_rep_nxt;
  status_t                 status_r, status_nxt;
  logic                    reload_top_r, reload_top_nxt, reload_max_r, reload_max_nxt;

  logic signed [KEY_W-1:0] res_top_key_r, res_top_key_nxt, res_max_key_r, res_max_key_nxt;
  logic signed [VAL_W-1:0] res_top_val_r, res_top_val_nxt;
  logic                    res_empty_r, res_empty_nxt;
  status_t                 res_status_r, res_status_nxt;

  logic              pair_we, pair_re, max_we, max_re;
  logic [ADDR_W-1:0] pair_waddr, pair_raddr, max_waddr, max_raddr;
  logic [PAIR_W-1:0] pair_rdata;
  logic [MAX_W-1:0]  max_rdata;

  assign fill_m1 = fill_r - CNT_W'(1);
  assign fill_m2 = fill_r - CNT_W'(2);
  assign mc_m1   = mc_r - CNT_W'(1);
  assign mc_m2   = mc_r - CNT_W'(2);

  always_comb begin
    fill_nxt        = fill_r;
    mc_nxt          = mc_r;
    top_key_nxt     = top_key_r;
    top_val_nxt     = top_val_r;
    max_key_nxt     = max_key_r;
    max_rep_nxt     = max_rep_r;
    status_nxt      = status_r;
    reload_top_nxt  = reload_top_r;
    reload_max_nxt  = reload_max_r;
    res_top_key_nxt = res_top_key_r;
    res_top_val_nxt = res_top_val_r;
    res_max_key_nxt = res_max_key_r;
    res_empty_nxt   = res_empty_r;
    res_status_nxt  = res_status_r;
    pair_we         = 1'b0;
    pair_re         = 1'b0;
    max_we          = 1'b0;
    max_re          = 1'b0;
    pair_waddr      = fill_m1[ADDR_W-1:0];
    pair_raddr      = fill_m2[ADDR_W-1:0];
    max_waddr       = mc_m1[ADDR_W-1:0];
    max_raddr       = mc_m2[ADDR_W-1:0];

    if (cmd.start) begin
      status_nxt     = ST_OK;
      reload_top_nxt = 1'b0;
      reload_max_nxt = 1'b0;
      if (in_func == FUNC_PUSH) begin
        if (fill_r == CNT_W'(STACK_DEPTH)) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          // The old top pair moves down into the store.
          pair_we     = (fill_r != '0);
          top_key_nxt = in_key;
          top_val_nxt = in_value;
          fill_nxt    = fill_r + CNT_W'(1);
          if (fill_r == '0 || mc_r == '0) begin
            max_key_nxt = in_key;
            max_rep_nxt = CNT_W'(1);
            mc_nxt      = CNT_W'(1);
          end else if (in_key > max_key_r) begin
            if (mc_r < CNT_W'(STACK_DEPTH)) begin
              max_we      = 1'b1;
              max_key_nxt = in_key;
              max_rep_nxt = CNT_W'(1);
              mc_nxt      = mc_r + CNT_W'(1);
            end
          end else if (in_key == max_key_r) begin
            max_rep_nxt = max_rep_r + CNT_W'(1);
          end
        end
      end else begin
        if (fill_r == '0) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          fill_nxt       = fill_m1;
          pair_re        = 1'b1;
          reload_top_nxt = (fill_m1 != '0);
          if (top_key_r == max_key_r) begin
            if (max_rep_r > CNT_W'(1)) begin
              max_rep_nxt = max_rep_r - CNT_W'(1);
            end else begin
              mc_nxt         = mc_m1;
              max_re         = 1'b1;
              reload_max_nxt = (mc_m1 != '0);
            end
          end
          if (fill_m1 == '0) begin
            mc_nxt         = '0;
            reload_max_nxt = 1'b0;
          end
        end
      end
    end else if (cmd.finish) begin
      if (reload_top_r) begin
        top_key_nxt = pair_rdata[KEY_W-1:0];
        top_val_nxt = pair_rdata[PAIR_W-1:KEY_W];
      end
      if (reload_max_r) begin
        max_key_nxt = max_rdata[KEY_W-1:0];
        max_rep_nxt = max_rdata[MAX_W-1:KEY_W];
      end
      reload_top_nxt = 1'b0;
      reload_max_nxt = 1'b0;
      res_status_nxt = status_r;
      if (fill_r == '0) begin
        res_top_key_nxt = '0;
        res_top_val_nxt = '0;
        res_max_key_nxt = '0;
        res_empty_nxt   = 1'b1;
      end else begin
        res_top_key_nxt = top_key_nxt;
        res_top_val_nxt = top_val_nxt;
        res_max_key_nxt = max_key_nxt;
        res_empty_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      mc_r         <= '0;
      reload_top_r <= 1'b0;
      reload_max_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      mc_r         <= mc_nxt;
      reload_top_r <= reload_top_nxt;
      reload_max_r <= reload_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_key_r     <= top_key_nxt;
    top_val_r     <= top_val_nxt;
    max_key_r     <= max_key_nxt;
    max_rep_r     <= max_rep_nxt;
    status_r      <= status_nxt;
    res_top_key_r <= res_top_key_nxt;
    res_top_val_r <= res_top_val_nxt;
    res_max_key_r <= res_max_key_nxt;
    res_empty_r   <= res_empty_nxt;
    res_status_r  <= res_status_nxt;
  end

  smt_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STACK_DEPTH)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata ({top_val_r, top_key_r}),
    .re    (pair_re),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  smt_ram #(
    .WIDTH (MAX_W),
    .DEPTH (STACK_DEPTH)
  ) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (max_waddr),
    .wdata ({max_rep_r, max_key_r}),
    .re    (max_re),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  assign out_top_key   = res_top_key_r;
  assign out_top_value = res_top_val_r;
  assign out_max_key   = res_max_key_r;
  assign out_is_empty  = res_empty_r;
  assign out_status    = res_status_r;

endmodule

FILE: rtl/stack_with_max_tracking.sv
// A new transaction is accepted only after the previous one has been handed
// to the output register, since a pop needs the registered read of the pair
// and maxima RAMs before the new top is known.
// A waiting result is held in the output register while the next transaction
// is accepted; the following one waits only if that result is still untaken.
// Reset (rst_n, synchronous, active low) empties the stack at once: no pass.
// ----------------------------------------------------------------------------
// stack_with_max_tracking : LIFO of key/value pairs with running maximum
// Each transaction pushes or pops one pair and returns the top pair, the
// largest key held, an empty flag and a status code.
// ----------------------------------------------------------------------------
module stack_with_max_tracking
  import smt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] push_key, [63:32] push_value
  input  logic [0:0]  in_tuser,   // [0] func (0 push, 1 pop)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] top_key, [63:32] top_value, [95:64] max_key
  output logic [2:0]  out_tuser   // [0] is_empty, [2:1] status
);

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath. The two are joined by the command bundle alone.
  smt_cmd_t                cmd;
  logic signed [KEY_W-1:0] top_key, max_key;
  logic signed [VAL_W-1:0] top_value;
  logic                    is_empty;
  status_t                 status;

  smt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // A pop ignores the key and value lanes; they are passed on regardless.
  smt_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_func       (in_tuser[0]),
    .in_key        (in_tdata[31:0]),
    .in_value      (in_tdata[63:32]),
    .out_top_key   (top_key),
    .out_top_value (top_value),
    .out_max_key   (max_key),
    .out_is_empty  (is_empty),
    .out_status    (status)
  );

  // Results travel in the same field order as they are listed above.
  assign out_tdata = {max_key, top_value, top_key};
  assign out_tuser = {status, is_empty};

endmodule

FILE: rtl/smt_checker.sv
// ----------------------------------------------------------------------------
// smt_checker : port-level checks for the max-tracking stack
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module smt_checker
  import smt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // No result may appear straight out of reset.
  a_reset_quiet : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented after reset");

  // An empty stack reports zeros for the top pair and the maximum.
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("empty stack reports non-zero data");

  // A refused pop can only happen on an empty stack.
  a_underflow_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ST_UNDERFLOW |-> out_tuser[0])
    else $error("underflow reported on a non-empty stack");

  // A refused push can only happen on a full, hence non-empty, stack.
  a_overflow_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ST_OVERFLOW |-> !out_tuser[0])
    else $error("overflow reported on an empty stack");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind stack_with_max_tracking smt_checker u_smt_checker (.*);
